// ----- rtl/core/rfs_pkg.sv -----
// Shared constants, types and rounding helpers for the rotation field block.
package rfs_pkg;

  // Fraction bits of sine and cosine values (signed Q1.ANGLE_BITS)
  localparam int ANGLE_BITS = 16;
  localparam int TW         = ANGLE_BITS + 2;  // trig value width
  localparam int PW         = 26;              // position width, signed Q9.16
  localparam int OUT_W      = 28;              // result width, signed Q11.16

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [33:0] PI_Q32  = 34'h3_243F_6A88;

  // Horner divisors and their reciprocals, scaled by 2^31
  localparam logic [31:0] RCP_NUM = 32'h8000_0000;
  localparam logic [6:0]  K_SIN   [0:3] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [30:0] RCP_SIN [0:3] = '{31'(RCP_NUM / 32'd72), 31'(RCP_NUM / 32'd42),
                                            31'(RCP_NUM / 32'd20), 31'(RCP_NUM / 32'd6)};
  localparam logic [6:0]  K_COS   [0:4] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [30:0] RCP_COS [0:4] = '{31'(RCP_NUM / 32'd90), 31'(RCP_NUM / 32'd56),
                                            31'(RCP_NUM / 32'd30), 31'(RCP_NUM / 32'd12),
                                            31'(RCP_NUM / 32'd2)};

  // Pipeline depth: trig outputs registered at stage TRIG_LAT, results at OUT_LAT
  localparam int TRIG_LAT = 18;
  localparam int OUT_LAT  = TRIG_LAT + 5;

  // Register indexes
  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_VX   = 2'd1,
    REG_VY   = 2'd2,
    REG_VZ   = 2'd3
  } cfg_idx_t;

  localparam logic MODE_ROTATE = 1'b0;

  // Quadrant and fold flag carried alongside the trig chain
  typedef struct packed {
    logic [1:0] quad;
    logic       fold;
  } trig_meta_t;

  // Divide by 2^sh, rounding half away from zero (sh >= 1)
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] half;
    begin
      mag  = v[63] ? 64'(-v) : 64'(v);
      half = 64'd1 << (sh - 1);
      mag  = (mag + half) >> sh;
      return v[63] ? -$signed(mag) : $signed(mag);
    end
  endfunction

  // Clamp to the result range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    begin
      hi = 64'sd134217727;
      lo = -64'sd134217728;
      if (v > hi) return OUT_W'(hi);
      if (v < lo) return OUT_W'(lo);
      return OUT_W'(v);
    end
  endfunction

endpackage

// ----- rtl/core/rfs_hstep.sv -----
// One Horner step, 1 - ((x2 * p) >> 30) / k, over three register stages.
module rfs_hstep (
  input  logic        clk,
  input  logic [29:0] x2_i,
  input  logic [30:0] p_i,
  input  logic [6:0]  k_i,
  input  logic [30:0] rcp_i,
  output logic [29:0] x2_o,
  output logic [30:0] p_o
);

  logic [60:0] prod1;
  logic [29:0] m_nxt;
  logic [29:0] m_r;
  logic [29:0] x2a_r;
  logic [60:0] prod2;
  logic [29:0] q0_nxt;
  logic [29:0] q0_r;
  logic [29:0] m2_r;
  logic [29:0] x2b_r;
  logic [37:0] qk;
  logic [37:0] rem;
  logic [29:0] q;
  logic [30:0] p_nxt;
  logic [30:0] p_r;
  logic [29:0] x2c_r;

  // stage 1: Q30 product
  assign prod1 = 61'(x2_i) * 61'(p_i);
  assign m_nxt = prod1[59:30];

  // stage 2: quotient estimate by reciprocal, low by at most one
  assign prod2  = 61'(m_r) * 61'(rcp_i);
  assign q0_nxt = prod2[60:31];

  // stage 3: correct quotient, subtract from one
  assign qk    = 38'(q0_r) * 38'(k_i);
  assign rem   = 38'(m2_r) - qk;
  assign q     = q0_r + 30'(rem >= 38'(k_i));
  assign p_nxt = rfs_pkg::Q30_ONE - {1'b0, q};

  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    x2a_r <= x2_i;
    q0_r  <= q0_nxt;
    m2_r  <= m_r;
    x2b_r <= x2a_r;
    p_r   <= p_nxt;
    x2c_r <= x2b_r;
  end

  assign p_o  = p_r;
  assign x2_o = x2c_r;

endmodule

// ----- rtl/core/rfs_trig.sv -----
// Pipelined sine and cosine of a 16-bit angle by octant folding and Horner series.
module rfs_trig (
  input  logic                           clk,
  input  logic [15:0]                    angle_i,
  output logic signed [rfs_pkg::TW-1:0]  sin_o,
  output logic signed [rfs_pkg::TW-1:0]  cos_o
);

  logic [13:0]         off;
  logic                fold;
  logic [13:0]         t;
  logic [47:0]         xprod;
  logic [47:0]         xsum;
  logic [29:0]         x_r;
  rfs_pkg::trig_meta_t md_r [0:16];
  logic [59:0]         sq;
  logic [29:0]         x2_r;
  logic [29:0]         xdl_r [0:12];
  logic [29:0]         sx2 [0:4];
  logic [30:0]         sp  [0:4];
  logic [29:0]         cx2 [0:5];
  logic [30:0]         cp  [0:5];
  logic [60:0]         sprod;
  logic [29:0]         s_r;
  logic [29:0]         sd1_r;
  logic [29:0]         sd2_r;
  logic [30:0]         sv;
  logic [30:0]         s0;
  logic [30:0]         c0;
  logic signed [31:0]  sgn_s;
  logic signed [31:0]  sgn_c;
  logic signed [63:0]  s_rnd;
  logic signed [63:0]  c_rnd;
  logic signed [rfs_pkg::TW-1:0] sin_r;
  logic signed [rfs_pkg::TW-1:0] cos_r;

  // stage 1: fold into the first octant, convert to radians in Q30
  assign off   = angle_i[13:0];
  assign fold  = off > 14'd8192;
  assign t     = fold ? 14'(15'd16384 - {1'b0, off}) : off;
  assign xprod = 48'(t) * 48'(rfs_pkg::PI_Q32);
  assign xsum  = xprod + 48'h1_0000;

  // stage 2: square of the angle
  assign sq = 60'(x_r) * 60'(x_r);

  always_ff @(posedge clk) begin
    x_r          <= xsum[46:17];
    md_r[0].quad <= angle_i[15:14];
    md_r[0].fold <= fold;
    for (int i = 1; i <= 16; i++) begin
      md_r[i] <= md_r[i-1];
    end
    x2_r     <= sq[59:30];
    xdl_r[0] <= x_r;
    for (int i = 1; i <= 12; i++) begin
      xdl_r[i] <= xdl_r[i-1];
    end
  end

  // sine series chain, terms to x^9
  assign sx2[0] = x2_r;
  assign sp[0]  = rfs_pkg::Q30_ONE;
  for (genvar g = 0; g < 4; g++) begin : g_sin
    rfs_hstep u_step (
      .clk   (clk),
      .x2_i  (sx2[g]),
      .p_i   (sp[g]),
      .k_i   (rfs_pkg::K_SIN[g]),
      .rcp_i (rfs_pkg::RCP_SIN[g]),
      .x2_o  (sx2[g+1]),
      .p_o   (sp[g+1])
    );
  end

  // cosine series chain, terms to x^10
  assign cx2[0] = x2_r;
  assign cp[0]  = rfs_pkg::Q30_ONE;
  for (genvar g = 0; g < 5; g++) begin : g_cos
    rfs_hstep u_step (
      .clk   (clk),
      .x2_i  (cx2[g]),
      .p_i   (cp[g]),
      .k_i   (rfs_pkg::K_COS[g]),
      .rcp_i (rfs_pkg::RCP_COS[g]),
      .x2_o  (cx2[g+1]),
      .p_o   (cp[g+1])
    );
  end

  // final sine multiply, then delay to line up with the longer cosine chain
  assign sprod = 61'(xdl_r[12]) * 61'(sp[4]);

  always_ff @(posedge clk) begin
    s_r   <= sprod[59:30];
    sd1_r <= s_r;
    sd2_r <= sd1_r;
  end

  // unfold octant, map quadrant, round to output precision
  assign sv = {1'b0, sd2_r};
  assign s0 = md_r[16].fold ? cp[5] : sv;
  assign c0 = md_r[16].fold ? sv : cp[5];

  always_comb begin
    case (md_r[16].quad)
      2'd0: begin
        sgn_s = $signed({1'b0, s0});
        sgn_c = $signed({1'b0, c0});
      end
      2'd1: begin
        sgn_s = $signed({1'b0, c0});
        sgn_c = -$signed({1'b0, s0});
      end
      2'd2: begin
        sgn_s = -$signed({1'b0, s0});
        sgn_c = -$signed({1'b0, c0});
      end
      default: begin
        sgn_s = -$signed({1'b0, c0});
        sgn_c = $signed({1'b0, s0});
      end
    endcase
  end

  assign s_rnd = rfs_pkg::rnd_sh(64'(sgn_s), 30 - rfs_pkg::ANGLE_BITS);
  assign c_rnd = rfs_pkg::rnd_sh(64'(sgn_c), 30 - rfs_pkg::ANGLE_BITS);

  always_ff @(posedge clk) begin
    sin_r <= s_rnd[rfs_pkg::TW-1:0];
    cos_r <= c_rnd[rfs_pkg::TW-1:0];
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ----- rtl/core/rotation_field_from_spherical.sv -----
// Top level: spherical grid point to rotation or constant field vector, fully pipelined.
//
// One request is taken in every clock cycle (busy stays low); each gives exactly one
// result, strobed on out_valid. Most of the pipeline lies in the trig unit: octant fold,
// angle square, five three-stage cosine Horner steps and the unfold and rounding stage;
// position products, cross product and rounding add five more stages.
// Results cannot be held off. Write the configuration only while no request is in flight.
module rotation_field_from_spherical (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [23:0]                      in_radius,
  input  logic [15:0]                      in_polar_angle,
  input  logic [15:0]                      in_azimuth,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [15:0]                      cfg_wdata,
  output logic                             out_valid,
  output logic signed [rfs_pkg::OUT_W-1:0] out_field_x,
  output logic signed [rfs_pkg::OUT_W-1:0] out_field_y,
  output logic signed [rfs_pkg::OUT_W-1:0] out_field_z
);

  localparam int PW = rfs_pkg::PW;
  localparam int TW = rfs_pkg::TW;

  logic                        accept;
  logic                        mode_r;
  logic signed [15:0]          vx_r;
  logic signed [15:0]          vy_r;
  logic signed [15:0]          vz_r;
  logic [rfs_pkg::OUT_LAT-1:0] vld_r;
  logic [23:0]                 rad_r [0:rfs_pkg::TRIG_LAT];
  logic signed [TW-1:0]        st;
  logic signed [TW-1:0]        ct;
  logic signed [TW-1:0]        sp;
  logic signed [TW-1:0]        cp;
  logic signed [63:0]          ux_nxt;
  logic signed [63:0]          uy_nxt;
  logic signed [63:0]          pz_nxt;
  logic signed [TW-1:0]        ux_r;
  logic signed [TW-1:0]        uy_r;
  logic signed [PW-1:0]        pz_r;
  logic signed [63:0]          px_nxt;
  logic signed [63:0]          py_nxt;
  logic signed [PW-1:0]        px_r;
  logic signed [PW-1:0]        py_r;
  logic signed [PW-1:0]        pzd_r;
  logic signed [41:0]          a1_r, a2_r, b1_r, b2_r, c1_r, c2_r;
  logic signed [42:0]          dx_r, dy_r, dz_r;
  logic signed [rfs_pkg::OUT_W-1:0] fx_nxt, fy_nxt, fz_nxt;
  logic signed [rfs_pkg::OUT_W-1:0] fx_r, fy_r, fz_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rfs_pkg::MODE_ROTATE;
      vx_r   <= 16'sd0;
      vy_r   <= 16'sd0;
      vz_r   <= 16'sd16384;
    end else if (cfg_we) begin
      case (rfs_pkg::cfg_idx_t'(cfg_index))
        rfs_pkg::REG_MODE: mode_r <= cfg_wdata[0];
        rfs_pkg::REG_VX:   vx_r   <= $signed(cfg_wdata);
        rfs_pkg::REG_VY:   vy_r   <= $signed(cfg_wdata);
        rfs_pkg::REG_VZ:   vz_r   <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[rfs_pkg::OUT_LAT-2:0], accept};
    end
  end

  // radius waits alongside the trig units
  always_ff @(posedge clk) begin
    rad_r[0] <= in_radius;
    for (int i = 1; i <= rfs_pkg::TRIG_LAT; i++) begin
      rad_r[i] <= rad_r[i-1];
    end
  end

  rfs_trig u_trig_polar (
    .clk     (clk),
    .angle_i (in_polar_angle),
    .sin_o   (st),
    .cos_o   (ct)
  );

  rfs_trig u_trig_azim (
    .clk     (clk),
    .angle_i (in_azimuth),
    .sin_o   (sp),
    .cos_o   (cp)
  );

  // direction products and z position
  assign ux_nxt = rfs_pkg::rnd_sh(64'(st * cp), rfs_pkg::ANGLE_BITS);
  assign uy_nxt = rfs_pkg::rnd_sh(64'(st * sp), rfs_pkg::ANGLE_BITS);
  assign pz_nxt = rfs_pkg::rnd_sh(
      64'($signed({1'b0, rad_r[rfs_pkg::TRIG_LAT-1]}) * ct), rfs_pkg::ANGLE_BITS);

  // x and y position
  assign px_nxt = rfs_pkg::rnd_sh(
      64'($signed({1'b0, rad_r[rfs_pkg::TRIG_LAT]}) * ux_r), rfs_pkg::ANGLE_BITS);
  assign py_nxt = rfs_pkg::rnd_sh(
      64'($signed({1'b0, rad_r[rfs_pkg::TRIG_LAT]}) * uy_r), rfs_pkg::ANGLE_BITS);

  // final rounding, saturation and mode select
  always_comb begin
    if (mode_r == rfs_pkg::MODE_ROTATE) begin
      fx_nxt = rfs_pkg::sat_out(rfs_pkg::rnd_sh(64'(dx_r), 14));
      fy_nxt = rfs_pkg::sat_out(rfs_pkg::rnd_sh(64'(dy_r), 14));
      fz_nxt = rfs_pkg::sat_out(rfs_pkg::rnd_sh(64'(dz_r), 14));
    end else begin
      fx_nxt = {{10{vx_r[15]}}, vx_r, 2'b00};
      fy_nxt = {{10{vy_r[15]}}, vy_r, 2'b00};
      fz_nxt = {{10{vz_r[15]}}, vz_r, 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    ux_r  <= ux_nxt[TW-1:0];
    uy_r  <= uy_nxt[TW-1:0];
    pz_r  <= pz_nxt[PW-1:0];
    px_r  <= px_nxt[PW-1:0];
    py_r  <= py_nxt[PW-1:0];
    pzd_r <= pz_r;
    // cross product terms
    a1_r  <= vy_r * pzd_r;
    a2_r  <= vz_r * py_r;
    b1_r  <= vz_r * px_r;
    b2_r  <= vx_r * pzd_r;
    c1_r  <= vx_r * py_r;
    c2_r  <= vy_r * px_r;
    dx_r  <= 43'(a1_r) - 43'(a2_r);
    dy_r  <= 43'(b1_r) - 43'(b2_r);
    dz_r  <= 43'(c1_r) - 43'(c2_r);
    fx_r  <= fx_nxt;
    fy_r  <= fy_nxt;
    fz_r  <= fz_nxt;
  end

  assign out_valid   = vld_r[rfs_pkg::OUT_LAT-1];
  assign out_field_x = fx_r;
  assign out_field_y = fy_r;
  assign out_field_z = fz_r;

  // checks
  logic zero_rot;
  assign zero_rot = (mode_r == rfs_pkg::MODE_ROTATE) && (vx_r == 16'sd0) &&
                    (vy_r == 16'sd0) && (vz_r == 16'sd0);

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> $past(accept, rfs_pkg::OUT_LAT))
    else $error("result without matching request");

  a_zero_vector_zero_field: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && $past(zero_rot, 1) && $past(zero_rot, 2) && $past(zero_rot, 3))
      |-> (out_field_x == '0 && out_field_y == '0 && out_field_z == '0))
    else $error("zero rotation vector gave a non-zero field");

endmodule
